// ----- design/lpp_pkg.sv -----
// Shared constants, types and helpers of the loop path lookahead planner.
`timescale 1ns / 1ps
package lpp_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int SLOT_W     = $clog2(MAX_POINTS);
  localparam int PL_W       = 11;
  localparam int MAX_AHEAD  = 64;
  localparam int CNT_W      = 7;
  localparam int COORD_BITS = 24;
  localparam int CB         = COORD_BITS;
  localparam int DW         = CB + 1;
  localparam int Q_W        = 16;
  localparam int SQ_W       = 2 * CB;
  localparam int R_W        = CB + 1;
  localparam int P_W        = CB + 2;
  localparam int FRAC       = 29;
  localparam int NUM_W      = 2 * ((P_W + FRAC + 1) / 2);
  localparam int RT_W       = NUM_W / 2;
  localparam int STEP_W     = $clog2(NUM_W + 1);
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [Q_W-1:0]  Q_MAX      = 16'h7fff;
  localparam logic [1:0]      STAT_PATH  = 2'd0;
  localparam logic [1:0]      STAT_DOCK  = 2'd1;
  localparam logic [1:0]      STAT_NOPATH = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_PATH_LEN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AHEAD    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOOP     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DOCK_X   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DOCK_Y   = 3'd5;

  typedef enum logic [1:0] {K_LOAD, K_NOPATH, K_DOCK, K_PLAN} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [SLOT_W-1:0]      slot;
    logic signed [CB-1:0]   sx;
    logic signed [CB-1:0]   sy;
    logic signed [Q_W-1:0]  sqz;
    logic signed [Q_W-1:0]  sqw;
    logic signed [CB-1:0]   gx;
    logic signed [CB-1:0]   gy;
    logic signed [Q_W-1:0]  gqz;
    logic signed [Q_W-1:0]  gqw;
  } cmd_t;

  typedef struct packed {
    logic [PL_W-1:0]        path_len;
    logic [CNT_W-1:0]       ahead;
    logic                   loop_mode;
    logic [PL_W-1:0]        margin;
    logic signed [CB-1:0]   dock_x;
    logic signed [CB-1:0]   dock_y;
  } cfg_t;

  typedef struct packed {
    logic                   start;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
  } head_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [Q_W-1:0]  qz;
    logic signed [Q_W-1:0]  qw;
  } head_rsp_t;

  function automatic logic [PL_W-1:0] eff_len(logic [PL_W-1:0] len);
    return (len > PL_W'(MAX_POINTS)) ? PL_W'(MAX_POINTS) : len;
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s,
                                                  logic [PL_W-1:0] n);
    logic [PL_W-1:0] inc;
    inc = PL_W'(s) + PL_W'(1);
    return (inc >= n) ? '0 : inc[SLOT_W-1:0];
  endfunction

  function automatic logic [CB-1:0] mag(logic signed [DW-1:0] v);
    return v[DW-1] ? CB'(-v) : CB'(v);
  endfunction

endpackage

// ----- design/lpp_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module lpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- design/lpp_head.sv -----
// Heading unit: yaw quaternion toward a direction via shared iterative sqrt and divider.
`timescale 1ns / 1ps
module lpp_head (
  input  logic                clk,
  input  logic                rst_n,
  input  lpp_pkg::head_req_t  req,
  output lpp_pkg::head_rsp_t  rsp
);
  import lpp_pkg::*;

  typedef enum logic [3:0] {
    H_IDLE, H_MA, H_MB, H_MS, H_RR, H_DW, H_RW, H_DZ, H_RZ
  } hstate_t;

  hstate_t               state_r;
  logic [CB-1:0]         ax_r, ay_r;
  logic                  negx_r, negy_r;
  logic [SQ_W-1:0]       prod_r, acc_r;
  logic [NUM_W-1:0]      sq_val_r;
  logic [RT_W+1:0]       sq_rem_r;
  logic [RT_W-1:0]       sq_root_r;
  logic [STEP_W-1:0]     step_r;
  logic [R_W-1:0]        r_r;
  logic [NUM_W-1:0]      dv_num_r, dv_q_r;
  logic [R_W-1:0]        dv_rem_r;
  logic [Q_W-1:0]        w_r;
  logic                  done_r;
  logic signed [Q_W-1:0] qz_r, qw_r;

  logic [RT_W+3:0]  rs, tr, rs_d;
  logic             rbit;
  logic [RT_W-1:0]  root_nxt;
  logic [R_W:0]     rn, rn_d;
  logic             qbit;
  logic [R_W-1:0]   r_nxt;
  logic [P_W-1:0]   pp, mm;
  logic [Q_W-1:0]   sat;
  logic             rt_last, dv_last;

  always_comb begin
    rs       = {sq_rem_r, sq_val_r[NUM_W-1 -: 2]};
    tr       = {2'b00, sq_root_r, 2'b01};
    rs_d     = rs - tr;
    rbit     = (rs >= tr);
    root_nxt = {sq_root_r[RT_W-2:0], rbit};
    rn       = {dv_rem_r, dv_num_r[NUM_W-1]};
    rn_d     = rn - {1'b0, r_r};
    qbit     = (rn >= {1'b0, r_r});
    r_nxt    = (state_r == H_RR) ? R_W'(root_nxt) : r_r;
    pp  = negx_r ? P_W'(r_nxt) - P_W'(ax_r) : P_W'(r_nxt) + P_W'(ax_r);
    mm  = negx_r ? P_W'(r_nxt) + P_W'(ax_r) : P_W'(r_nxt) - P_W'(ax_r);
    sat = (root_nxt > RT_W'(Q_MAX)) ? Q_MAX : root_nxt[Q_W-1:0];
    rt_last = (step_r == STEP_W'(RT_W - 1));
    dv_last = (step_r == STEP_W'(NUM_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        H_IDLE: begin
          done_r <= req.start && req.dx == '0 && req.dy == '0;
          if (req.start) begin
            ax_r   <= mag(req.dx);
            ay_r   <= mag(req.dy);
            negx_r <= req.dx[DW-1];
            negy_r <= req.dy[DW-1];
            if (req.dx == '0 && req.dy == '0) begin
              qz_r   <= '0;
              qw_r   <= Q_MAX;
            end else begin
              state_r <= H_MA;
            end
          end
        end
        H_MA: begin
          done_r  <= 1'b0;
          prod_r  <= ax_r * ax_r;
          state_r <= H_MB;
        end
        H_MB: begin
          done_r  <= 1'b0;
          acc_r   <= prod_r;
          prod_r  <= ay_r * ay_r;
          state_r <= H_MS;
        end
        H_MS: begin
          done_r    <= 1'b0;
          sq_val_r  <= NUM_W'(acc_r) + NUM_W'(prod_r);
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          step_r    <= '0;
          state_r   <= H_RR;
        end
        H_RR, H_RW, H_RZ: begin
          done_r    <= (state_r == H_RZ) && rt_last;
          sq_rem_r  <= rbit ? rs_d[RT_W+1:0] : rs[RT_W+1:0];
          sq_root_r <= root_nxt;
          sq_val_r  <= sq_val_r << 2;
          step_r    <= rt_last ? '0 : step_r + STEP_W'(1);
          if (rt_last) begin
            if (state_r == H_RR) begin
              state_r  <= H_DW;
              dv_num_r <= NUM_W'(pp) << FRAC;
              dv_rem_r <= '0;
            end else if (state_r == H_RW) begin
              w_r      <= sat;
              state_r  <= H_DZ;
              dv_num_r <= NUM_W'(mm) << FRAC;
              dv_rem_r <= '0;
            end else begin
              qw_r    <= w_r;
              qz_r    <= negy_r ? -sat : sat;
              state_r <= H_IDLE;
            end
          end
        end
        H_DW, H_DZ: begin
          done_r   <= 1'b0;
          dv_rem_r <= qbit ? rn_d[R_W-1:0] : rn[R_W-1:0];
          dv_q_r   <= {dv_q_r[NUM_W-2:0], qbit};
          dv_num_r <= dv_num_r << 1;
          step_r   <= dv_last ? '0 : step_r + STEP_W'(1);
          if (dv_last) begin
            sq_val_r  <= {dv_q_r[NUM_W-2:0], qbit};
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            state_r   <= (state_r == H_DW) ? H_RW : H_RZ;
          end
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= H_IDLE;
        end
      endcase
      if (state_r == H_RR && rt_last) begin
        r_r <= r_nxt;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.qz   = qz_r;
  assign rsp.qw   = qw_r;
endmodule

// ----- design/lpp_front.sv -----
// Front end: accepts input transactions, classifies them and queues commands.
`timescale 1ns / 1ps
module lpp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpp_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [lpp_pkg::SLOT_W-1:0] in_point_index,
  input  logic signed [lpp_pkg::CB-1:0]  in_start_x,
  input  logic signed [lpp_pkg::CB-1:0]  in_start_y,
  input  logic signed [lpp_pkg::Q_W-1:0] in_start_qz,
  input  logic signed [lpp_pkg::Q_W-1:0] in_start_qw,
  input  logic signed [lpp_pkg::CB-1:0]  in_goal_x,
  input  logic signed [lpp_pkg::CB-1:0]  in_goal_y,
  input  logic signed [lpp_pkg::Q_W-1:0] in_goal_qz,
  input  logic signed [lpp_pkg::Q_W-1:0] in_goal_qw,
  output logic                       q_valid,
  input  logic                       q_ready,
  output lpp_pkg::cmd_t              q_cmd
);
  import lpp_pkg::*;

  cmd_t       fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       push, pop;

  always_comb begin
    cmd.slot = in_point_index;
    cmd.sx   = in_start_x;
    cmd.sy   = in_start_y;
    cmd.sqz  = in_start_qz;
    cmd.sqw  = in_start_qw;
    cmd.gx   = in_goal_x;
    cmd.gy   = in_goal_y;
    cmd.gqz  = in_goal_qz;
    cmd.gqw  = in_goal_qw;
    if (!in_req_type) begin
      cmd.kind = K_LOAD;
    end else if (cfg.path_len == '0) begin
      cmd.kind = K_NOPATH;
    end else if (in_goal_x == cfg.dock_x && in_goal_y == cfg.dock_y) begin
      cmd.kind = K_DOCK;
    end else begin
      cmd.kind = K_PLAN;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- design/lpp_back.sv -----
// Back end: waypoint store writes, dock and no-path results, nearest point scan and lookahead emission.
`timescale 1ns / 1ps
module lpp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpp_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  lpp_pkg::cmd_t                 q_cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [lpp_pkg::CB-1:0]  out_pose_x,
  output logic signed [lpp_pkg::CB-1:0]  out_pose_y,
  output logic signed [lpp_pkg::Q_W-1:0] out_orient_z,
  output logic signed [lpp_pkg::Q_W-1:0] out_orient_w,
  output logic [lpp_pkg::SLOT_W-1:0]     out_path_slot,
  output logic [1:0]                     out_status,
  output logic                           out_last
);
  import lpp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CNT, S_RD, S_RDW, S_NRD, S_NRDW, S_HEAD, S_DOCK2, S_OUTW
  } state_t;

  state_t              state_r, after_r;
  cmd_t                cmd_r;
  logic [PL_W-1:0]     n_r, scan_i_r;
  logic                v0_r, v1_r, v2_r;
  logic [SLOT_W-1:0]   t0_r, t1_r, t2_r;
  logic [CB-1:0]       ex_r, ey_r;
  logic [SQ_W-1:0]     sqa_r, sqb_r;
  logic [SQ_W:0]       best_r;
  logic [SLOT_W-1:0]   idx_r;
  logic [CNT_W-1:0]    k_r;
  logic signed [CB-1:0] px_r, py_r;

  logic                 out_valid_r, out_last_r;
  logic signed [CB-1:0] out_x_r, out_y_r;
  logic signed [Q_W-1:0] out_z_r, out_w_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [1:0]           out_status_r;

  logic                 ram_we;
  logic [SLOT_W-1:0]    raddr;
  logic [2*CB-1:0]      rdata;
  logic signed [CB-1:0] rd_x, rd_y;
  logic                 issuing;
  logic [SQ_W:0]        sum;
  logic [PL_W-1:0]      cnt_full;
  logic [CNT_W-1:0]     cnt;
  head_req_t            hreq;
  head_rsp_t            hrsp;

  assign rd_x    = rdata[2*CB-1:CB];
  assign rd_y    = rdata[CB-1:0];
  assign q_ready = (state_r == S_IDLE);
  assign ram_we  = (state_r == S_IDLE) && q_valid && (q_cmd.kind == K_LOAD);
  assign issuing = (scan_i_r < n_r);
  assign sum     = {1'b0, sqa_r} + {1'b0, sqb_r};

  always_comb begin
    case (state_r)
      S_SCAN:  raddr = scan_i_r[SLOT_W-1:0];
      S_NRD:   raddr = next_slot(idx_r, n_r);
      default: raddr = idx_r;
    endcase
    if (cfg.loop_mode) begin
      cnt_full = (n_r > cfg.margin) ? n_r - cfg.margin : '0;
    end else begin
      cnt_full = PL_W'(cfg.ahead);
    end
    cnt = (cnt_full > PL_W'(MAX_AHEAD)) ? CNT_W'(MAX_AHEAD) : cnt_full[CNT_W-1:0];
    hreq.start = (state_r == S_NRDW);
    hreq.dx    = DW'(rd_x) - DW'(px_r);
    hreq.dy    = DW'(rd_y) - DW'(py_r);
  end

  lpp_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.slot),
    .wdata ({q_cmd.sx, q_cmd.sy}),
    .raddr (raddr),
    .rdata (rdata)
  );

  lpp_head u_head (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            unique case (q_cmd.kind)
              K_LOAD: ;
              K_NOPATH: begin
                out_x_r <= '0; out_y_r <= '0; out_z_r <= '0; out_w_r <= '0;
                out_slot_r <= '0; out_status_r <= STAT_NOPATH; out_last_r <= 1'b1;
                out_valid_r <= 1'b1;
                after_r <= S_IDLE;
                state_r <= S_OUTW;
              end
              K_DOCK: begin
                out_x_r <= q_cmd.sx; out_y_r <= q_cmd.sy;
                out_z_r <= q_cmd.sqz; out_w_r <= q_cmd.sqw;
                out_slot_r <= '0; out_status_r <= STAT_DOCK; out_last_r <= 1'b0;
                out_valid_r <= 1'b1;
                after_r <= S_DOCK2;
                state_r <= S_OUTW;
              end
              K_PLAN: begin
                n_r      <= eff_len(cfg.path_len);
                scan_i_r <= '0;
                v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
                state_r  <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_DOCK2: begin
          out_x_r <= cmd_r.gx; out_y_r <= cmd_r.gy;
          out_z_r <= cmd_r.gqz; out_w_r <= cmd_r.gqw;
          out_slot_r <= '0; out_status_r <= STAT_DOCK; out_last_r <= 1'b1;
          out_valid_r <= 1'b1;
          after_r <= S_IDLE;
          state_r <= S_OUTW;
        end
        S_SCAN: begin
          if (issuing) scan_i_r <= scan_i_r + PL_W'(1);
          v0_r  <= issuing;
          t0_r  <= scan_i_r[SLOT_W-1:0];
          v1_r  <= v0_r;
          t1_r  <= t0_r;
          ex_r  <= mag(DW'(cmd_r.sx) - DW'(rd_x));
          ey_r  <= mag(DW'(cmd_r.sy) - DW'(rd_y));
          v2_r  <= v1_r;
          t2_r  <= t1_r;
          sqa_r <= ex_r * ex_r;
          sqb_r <= ey_r * ey_r;
          if (v2_r && (t2_r == '0 || sum < best_r)) begin
            best_r <= sum;
            idx_r  <= t2_r;
          end
          if (!issuing && !v0_r && !v1_r && !v2_r) state_r <= S_CNT;
        end
        S_CNT: begin
          k_r   <= cnt;
          idx_r <= next_slot(idx_r, n_r);
          state_r <= (cnt == '0) ? S_IDLE : S_RD;
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          px_r <= rd_x;
          py_r <= rd_y;
          if (k_r == CNT_W'(1)) begin
            state_r <= S_NRD;
          end else begin
            out_x_r <= rd_x; out_y_r <= rd_y;
            out_z_r <= cmd_r.gqz; out_w_r <= cmd_r.gqw;
            out_slot_r <= idx_r; out_status_r <= STAT_PATH; out_last_r <= 1'b0;
            out_valid_r <= 1'b1;
            k_r     <= k_r - CNT_W'(1);
            idx_r   <= next_slot(idx_r, n_r);
            after_r <= S_RD;
            state_r <= S_OUTW;
          end
        end
        S_NRD:  state_r <= S_NRDW;
        S_NRDW: state_r <= S_HEAD;
        S_HEAD: begin
          if (hrsp.done) begin
            out_x_r <= px_r; out_y_r <= py_r;
            out_z_r <= hrsp.qz; out_w_r <= hrsp.qw;
            out_slot_r <= idx_r; out_status_r <= STAT_PATH; out_last_r <= 1'b1;
            out_valid_r <= 1'b1;
            after_r <= S_IDLE;
            state_r <= S_OUTW;
          end
        end
        S_OUTW: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= after_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pose_x    = out_x_r;
  assign out_pose_y    = out_y_r;
  assign out_orient_z  = out_z_r;
  assign out_orient_w  = out_w_r;
  assign out_path_slot = out_slot_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !out_valid_r) else $error("result shown during scan");
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE && q_valid) else $error("store write outside idle");
  a_nopath_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == STAT_NOPATH |-> out_last_r)
    else $error("no-path result not final");
  a_valid_outw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUTW) else $error("result pending outside wait");
endmodule

// ----- design/loop_path_lookahead_planner.sv -----
// Top level of the loop path lookahead planner: register port, front end and back end.
`timescale 1ns / 1ps
// Load transactions write one waypoint. A plan transaction scans the first path length
// waypoints (at most 1024) through one RAM read port, one point per cycle, then emits
// each lookahead point after a RAM read, waiting for the output to be taken; the final
// point runs the shared iterative square root and divider unit. A two entry command
// queue lets new transactions enter meanwhile.
// The waypoint store is not cleared: plan only over slots that have been loaded.
module loop_path_lookahead_planner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpp_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [lpp_pkg::SLOT_W-1:0]     in_point_index,
  input  logic signed [lpp_pkg::CB-1:0]  in_start_x,
  input  logic signed [lpp_pkg::CB-1:0]  in_start_y,
  input  logic signed [lpp_pkg::Q_W-1:0] in_start_qz,
  input  logic signed [lpp_pkg::Q_W-1:0] in_start_qw,
  input  logic signed [lpp_pkg::CB-1:0]  in_goal_x,
  input  logic signed [lpp_pkg::CB-1:0]  in_goal_y,
  input  logic signed [lpp_pkg::Q_W-1:0] in_goal_qz,
  input  logic signed [lpp_pkg::Q_W-1:0] in_goal_qw,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [lpp_pkg::CB-1:0]  out_pose_x,
  output logic signed [lpp_pkg::CB-1:0]  out_pose_y,
  output logic signed [lpp_pkg::Q_W-1:0] out_orient_z,
  output logic signed [lpp_pkg::Q_W-1:0] out_orient_w,
  output logic [lpp_pkg::SLOT_W-1:0]     out_path_slot,
  output logic [1:0]                     out_status,
  output logic                           out_last
);
  import lpp_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic                 q_valid, q_ready;
  cmd_t                 q_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.path_len  <= '0;
      cfg_r.ahead     <= CNT_W'(64);
      cfg_r.loop_mode <= 1'b0;
      cfg_r.margin    <= PL_W'(50);
      cfg_r.dock_x    <= '0;
      cfg_r.dock_y    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATH_LEN: cfg_r.path_len  <= pwdata[PL_W-1:0];
        REG_AHEAD:    cfg_r.ahead     <= pwdata[CNT_W-1:0];
        REG_LOOP:     cfg_r.loop_mode <= pwdata[0];
        REG_MARGIN:   cfg_r.margin    <= pwdata[PL_W-1:0];
        REG_DOCK_X:   cfg_r.dock_x    <= pwdata[CB-1:0];
        REG_DOCK_Y:   cfg_r.dock_y    <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATH_LEN: prdata = 32'(cfg_r.path_len);
      REG_AHEAD:    prdata = 32'(cfg_r.ahead);
      REG_LOOP:     prdata = 32'(cfg_r.loop_mode);
      REG_MARGIN:   prdata = 32'(cfg_r.margin);
      REG_DOCK_X:   prdata = 32'($unsigned(cfg_r.dock_x));
      REG_DOCK_Y:   prdata = 32'($unsigned(cfg_r.dock_y));
      default:      prdata = '0;
    endcase
  end

  lpp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_point_index (in_point_index),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_start_qz    (in_start_qz),
    .in_start_qw    (in_start_qw),
    .in_goal_x      (in_goal_x),
    .in_goal_y      (in_goal_y),
    .in_goal_qz     (in_goal_qz),
    .in_goal_qw     (in_goal_qw),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd)
  );

  lpp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pose_x    (out_pose_x),
    .out_pose_y    (out_pose_y),
    .out_orient_z  (out_orient_z),
    .out_orient_w  (out_orient_w),
    .out_path_slot (out_path_slot),
    .out_status    (out_status),
    .out_last      (out_last)
  );
endmodule

// ----- tb/plan_tb_pkg.sv -----
// Request codes shared by the planner testbench and its checker.
`timescale 1ns / 1ps
package plan_tb_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PLAN = 1'b1;

endpackage

// ----- tb/plan_checker.sv -----
// Checker for the loop path planner: snoops register writes and both channels, predicts routes.
`timescale 1ns / 1ps
module plan_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpp_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [lpp_pkg::SLOT_W-1:0]     in_point_index,
  input  logic signed [lpp_pkg::CB-1:0]  in_start_x,
  input  logic signed [lpp_pkg::CB-1:0]  in_start_y,
  input  logic signed [lpp_pkg::Q_W-1:0] in_start_qz,
  input  logic signed [lpp_pkg::Q_W-1:0] in_start_qw,
  input  logic signed [lpp_pkg::CB-1:0]  in_goal_x,
  input  logic signed [lpp_pkg::CB-1:0]  in_goal_y,
  input  logic signed [lpp_pkg::Q_W-1:0] in_goal_qz,
  input  logic signed [lpp_pkg::Q_W-1:0] in_goal_qw,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [lpp_pkg::CB-1:0]  out_pose_x,
  input  logic signed [lpp_pkg::CB-1:0]  out_pose_y,
  input  logic signed [lpp_pkg::Q_W-1:0] out_orient_z,
  input  logic signed [lpp_pkg::Q_W-1:0] out_orient_w,
  input  logic [lpp_pkg::SLOT_W-1:0]     out_path_slot,
  input  logic [1:0]                     out_status,
  input  logic                           out_last,
  output int                             fail_count,
  output int                             pending
);
  import lpp_pkg::*;
  import plan_tb_pkg::*;

  typedef struct packed {
    logic signed [CB-1:0]  x;
    logic signed [CB-1:0]  y;
    logic signed [Q_W-1:0] qz;
    logic signed [Q_W-1:0] qw;
    logic [SLOT_W-1:0]     slot;
    logic [1:0]            status;
    logic                  last;
  } pose_t;

  pose_t                route_q[$];
  logic signed [CB-1:0] wp_x[MAX_POINTS];
  logic signed [CB-1:0] wp_y[MAX_POINTS];
  logic [PL_W-1:0]      path_len;
  logic [CNT_W-1:0]     ahead;
  logic                 loop_on;
  logic [PL_W-1:0]      margin;
  logic signed [CB-1:0] dock_x;
  logic signed [CB-1:0] dock_y;
  int                   mismatches;

  function automatic void add_pose(input pose_t p);
    route_q = {route_q, p};
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // yaw quaternion pointing along (dx, dy)
  function automatic void aim_quat(input longint dx, input longint dy,
                                   output logic signed [Q_W-1:0] qz,
                                   output logic signed [Q_W-1:0] qw);
    longint unsigned ax, ay, r, p, m, w, z;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
      ax >>= 1;
      ay >>= 1;
    end
    if (ax == 0 && ay == 0) begin
      qz = '0;
      qw = Q_MAX;
      return;
    end
    r = int_sqrt(ax * ax + ay * ay);
    if (dx >= 0) begin
      p = r + ax;
      m = r - ax;
    end else begin
      p = r - ax;
      m = r + ax;
    end
    w = int_sqrt((p << 29) / r);
    z = int_sqrt((m << 29) / r);
    if (w > 32767) w = 32767;
    if (z > 32767) z = 32767;
    qw = Q_W'(w);
    qz = dy < 0 ? -Q_W'(z) : Q_W'(z);
  endfunction

  task automatic plan_route();
    int n, cnt, cur, nxt;
    longint ex, ey;
    longint unsigned d, best_d;
    logic signed [Q_W-1:0] hz, hw;
    if (in_req_type == REQ_LOAD) begin
      wp_x[in_point_index] = in_start_x;
      wp_y[in_point_index] = in_start_y;
      return;
    end
    n = (path_len > MAX_POINTS) ? MAX_POINTS : path_len;
    if (n == 0) begin
      add_pose('{'0, '0, '0, '0, '0, STAT_NOPATH, 1'b1});
      return;
    end
    if (in_goal_x == dock_x && in_goal_y == dock_y) begin
      add_pose('{in_start_x, in_start_y, in_start_qz, in_start_qw, '0, STAT_DOCK, 1'b0});
      add_pose('{in_goal_x, in_goal_y, in_goal_qz, in_goal_qw, '0, STAT_DOCK, 1'b1});
      return;
    end
    cur = 0;
    best_d = 0;
    for (int i = 0; i < n; i++) begin
      ex = longint'(in_start_x) - longint'(wp_x[i]);
      ey = longint'(in_start_y) - longint'(wp_y[i]);
      d = ex * ex + ey * ey;
      if (i == 0 || d < best_d) begin
        best_d = d;
        cur = i;
      end
    end
    if (loop_on) cnt = (n > margin) ? n - margin : 0;
    else cnt = ahead;
    if (cnt > MAX_AHEAD) cnt = MAX_AHEAD;
    for (int k = 0; k < cnt; k++) begin
      cur = (cur + 1) % n;
      if (k == cnt - 1) begin
        nxt = (cur + 1) % n;
        aim_quat(longint'(wp_x[nxt]) - longint'(wp_x[cur]),
                 longint'(wp_y[nxt]) - longint'(wp_y[cur]), hz, hw);
        add_pose('{wp_x[cur], wp_y[cur], hz, hw, SLOT_W'(cur), STAT_PATH, 1'b1});
      end else begin
        add_pose('{wp_x[cur], wp_y[cur], in_goal_qz, in_goal_qw, SLOT_W'(cur),
                   STAT_PATH, 1'b0});
      end
    end
  endtask

  always @(posedge clk) begin
    pose_t exp_p, got;
    if (!rst_n) begin
      path_len = '0;
      ahead = CNT_W'(MAX_AHEAD);
      loop_on = 1'b0;
      margin = PL_W'(50);
      dock_x = '0;
      dock_y = '0;
      route_q.delete();
      fail_count = 0;
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_PATH_LEN: path_len = pwdata[PL_W-1:0];
          REG_AHEAD:    ahead = pwdata[CNT_W-1:0];
          REG_LOOP:     loop_on = pwdata[0];
          REG_MARGIN:   margin = pwdata[PL_W-1:0];
          REG_DOCK_X:   dock_x = pwdata[CB-1:0];
          REG_DOCK_Y:   dock_y = pwdata[CB-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_pose_x, out_pose_y, out_orient_z, out_orient_w, out_path_slot,
                out_status, out_last};
        if (route_q.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10) $display("unexpected pose transaction: %p", got);
        end else begin
          exp_p = route_q.pop_front();
          if (got.x !== exp_p.x || got.y !== exp_p.y || got.qz !== exp_p.qz ||
              got.qw !== exp_p.qw || got.slot !== exp_p.slot ||
              got.status !== exp_p.status || got.last !== exp_p.last) begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10)
              $display("pose mismatch at %0t: expected %p, got %p", $realtime, exp_p, got);
          end
        end
      end
      if (in_valid && in_ready) plan_route();
    end
    pending = route_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the planner testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module testbench;
  import lpp_pkg::*;
  import plan_tb_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 1600;
  localparam int HOLD_LEN = 3000;
  localparam int FILL     = 96;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [SLOT_W-1:0] in_point_index = '0;
  logic signed [CB-1:0] in_start_x = '0, in_start_y = '0, in_goal_x = '0, in_goal_y = '0;
  logic signed [Q_W-1:0] in_start_qz = '0, in_start_qw = '0, in_goal_qz = '0, in_goal_qw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CB-1:0] out_pose_x, out_pose_y;
  logic signed [Q_W-1:0] out_orient_z, out_orient_w;
  logic [SLOT_W-1:0] out_path_slot;
  logic [1:0] out_status;
  logic out_last;
  int fail_count, pending;

  logic quiet = 1'b0;
  logic hold_rx = 1'b0;
  logic signed [CB-1:0] wp_x[MAX_POINTS];
  logic signed [CB-1:0] wp_y[MAX_POINTS];
  logic signed [CB-1:0] dock_x = '0, dock_y = '0;
  int loaded;
  int stall_cnt = 0;

  always #1 clk = ~clk;

  loop_path_lookahead_planner DUT (.*);

  plan_checker u_checker (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic logic signed [CB-1:0] rnd_coord();
    int v;
    if ($urandom_range(1)) return CB'($urandom);
    v = $urandom_range(0, 4000) - 2000;
    return CB'(v);
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send(input logic rq, input logic [SLOT_W-1:0] slot,
                      input logic signed [CB-1:0] sx, input logic signed [CB-1:0] sy,
                      input logic signed [CB-1:0] gx, input logic signed [CB-1:0] gy);
    logic rdy;
    if (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_point_index <= slot;
    in_start_x <= sx;
    in_start_y <= sy;
    in_start_qz <= Q_W'($urandom);
    in_start_qw <= Q_W'($urandom);
    in_goal_x <= gx;
    in_goal_y <= gy;
    in_goal_qz <= Q_W'($urandom);
    in_goal_qw <= Q_W'($urandom);
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic load_wp(input int slot, input logic signed [CB-1:0] x,
                         input logic signed [CB-1:0] y);
    wp_x[slot] = x;
    wp_y[slot] = y;
    send(REQ_LOAD, SLOT_W'(slot), x, y, rnd_coord(), rnd_coord());
  endtask

  // plan from a start near a stored point (or anywhere); goal at dock on request
  task automatic plan(input bit at_dock);
    logic signed [CB-1:0] sx, sy;
    int s;
    if ($urandom_range(1)) begin
      s = $urandom_range(0, loaded - 1);
      sx = wp_x[s] + CB'($urandom_range(0, 6) - 3);
      sy = wp_y[s] + CB'($urandom_range(0, 6) - 3);
    end else begin
      sx = rnd_coord();
      sy = rnd_coord();
    end
    if (at_dock) send(REQ_PLAN, SLOT_W'($urandom), sx, sy, dock_x, dock_y);
    else send(REQ_PLAN, SLOT_W'($urandom), sx, sy, rnd_coord(), rnd_coord());
  endtask

  task automatic plan_from(input int s);
    send(REQ_PLAN, '0, wp_x[s], wp_y[s], rnd_coord(), rnd_coord());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    int plen, slot;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing loaded yet: error status, dock goal included
    loaded = 1;
    wp_x[0] = '0;
    wp_y[0] = '0;
    send(REQ_PLAN, '0, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    send(REQ_PLAN, '0, rnd_coord(), rnd_coord(), '0, '0);

    // small path with a repeated point, extremes and a westward step
    load_wp(0, 0, 0);
    load_wp(1, 0, 0);
    load_wp(2, 24'sh7fffff, 24'sh7fffff);
    load_wp(3, 1000, 5);
    load_wp(4, -1000, 5);
    load_wp(5, 24'sh800000, 24'sh800000);
    loaded = 6;
    settle();
    reg_write(REG_PATH_LEN, 6);
    reg_write(REG_AHEAD, 1);
    for (int i = 0; i < 6; i++) plan_from(i);
    settle();
    reg_write(REG_AHEAD, 127);
    plan_from(3);
    settle();
    reg_write(REG_AHEAD, 0);
    plan_from(1);
    plan(1'b1);
    settle();
    reg_write(REG_LOOP, 1);
    plan_from(2);
    settle();
    reg_write(REG_MARGIN, 0);
    plan_from(4);
    settle();
    reg_write(REG_MARGIN, 4);
    reg_write(REG_DOCK_X, 32'(24'sh800000));
    reg_write(REG_DOCK_Y, 32'(24'sh7fffff));
    dock_x = 24'sh800000;
    dock_y = 24'sh7fffff;
    plan_from(0);
    plan(1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      quiet = (ph == 3);
      plen = $urandom_range(1, loaded);
      reg_write(REG_PATH_LEN, plen);
      case ($urandom_range(5))
        0: reg_write(REG_AHEAD, 0);
        1: reg_write(REG_AHEAD, 1);
        2: reg_write(REG_AHEAD, 64);
        3: reg_write(REG_AHEAD, 127);
        default: reg_write(REG_AHEAD, $urandom_range(2, 20));
      endcase
      reg_write(REG_LOOP, 32'($urandom_range(3) == 0));
      reg_write(REG_MARGIN, $urandom_range(3) == 0 ? 1024 : $urandom_range(0, plen + 2));
      if ($urandom_range(1)) begin
        dock_x = rnd_coord();
        dock_y = rnd_coord();
        reg_write(REG_DOCK_X, 32'(dock_x));
        reg_write(REG_DOCK_Y, 32'(dock_y));
      end
      if (ph == 6) hold_rx = 1'b1;
      for (int it = 0; it < 20; it++) begin
        if ($urandom_range(3) == 0) begin
          slot = $urandom_range(0, loaded < 64 ? loaded : 63);
          load_wp(slot, rnd_coord(), rnd_coord());
          if (slot == loaded) loaded++;
        end else begin
          plan($urandom_range(4) == 0);
        end
      end
      quiet = 1'b0;
    end

    // grow the store, then plan over the longer loop
    settle();
    quiet = 1'b1;
    for (int s = loaded; s < FILL; s++) load_wp(s, rnd_coord(), rnd_coord());
    loaded = FILL;
    quiet = 1'b0;
    settle();
    reg_write(REG_PATH_LEN, FILL);
    reg_write(REG_LOOP, 0);
    reg_write(REG_AHEAD, 64);
    plan(1'b0);
    plan(1'b0);
    settle();
    reg_write(REG_LOOP, 1);
    reg_write(REG_MARGIN, 32'(FILL - 40));
    plan(1'b0);
    settle();
    reg_write(REG_MARGIN, 1024);
    plan(1'b0);
    settle();
    reg_write(REG_PATH_LEN, 0);
    plan(1'b1);
    settle();

    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
